// File: sv/rc4_pkg.sv
package rc4_pkg;

  localparam int BYTE_W        = 8;
  localparam int KEY_LEN_W     = 9;
  localparam int MAX_KEY_BYTES = 256;
  localparam int PERM_DEPTH    = 256;
  localparam int PERM_AW       = $clog2(PERM_DEPTH);
  localparam int KEY_AW        = $clog2(MAX_KEY_BYTES);

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_SCHED = 2'd1,
    CMD_DATA  = 2'd2,
    CMD_RSVD  = 2'd3
  } rc4_cmd_code_t;

  typedef enum logic [1:0] {
    ST_DATA_DONE  = 2'd0,
    ST_KEY_STORED = 2'd1,
    ST_SCHED_DONE = 2'd2,
    ST_REJECTED   = 2'd3
  } rc4_status_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_KEY_WR,
    OP_REJECT,
    OP_SCHED_START,
    OP_INIT_WR,
    OP_KS_RD_N,
    OP_KS_RD_J,
    OP_KS_WR_N,
    OP_KS_WR_J,
    OP_DATA_START,
    OP_DATA_RD_J,
    OP_DATA_WR_I,
    OP_DATA_WR_J
  } rc4_op_t;

  typedef struct packed {
    rc4_op_t op;
    logic    out_load;
  } rc4_cmd_t;

  typedef struct packed {
    logic n_last;
  } rc4_stat_t;

endpackage

// File: sv/rc4_if.sv
interface rc4_in_if import rc4_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            cmd;
  logic [BYTE_W-1:0]     key_index;
  logic [BYTE_W-1:0]     key_byte;
  logic [KEY_LEN_W-1:0]  key_length;
  logic [BYTE_W-1:0]     data_byte;

  modport source (output valid, cmd, key_index, key_byte, key_length, data_byte,
                  input ready);
  modport sink   (input valid, cmd, key_index, key_byte, key_length, data_byte,
                  output ready);
endinterface

interface rc4_out_if import rc4_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic [1:0]        status;

  modport source (output valid, out_byte, status, input ready);
  modport sink   (input valid, out_byte, status, output ready);
endinterface

// File: sv/rc4_ram.sv
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/rc4_dp.sv
module rc4_dp import rc4_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rc4_cmd_t             cmd,
  input  logic [BYTE_W-1:0]    in_key_index,
  input  logic [BYTE_W-1:0]    in_key_byte,
  input  logic [KEY_LEN_W-1:0] in_key_length,
  input  logic [BYTE_W-1:0]    in_data_byte,
  output rc4_stat_t            stat,
  output logic [BYTE_W-1:0]    out_byte
);

  logic [PERM_AW-1:0] i_r, i_nxt;
  logic [PERM_AW-1:0] j_r, j_nxt;
  logic [PERM_AW-1:0] n_r, n_nxt;
  logic [KEY_AW-1:0]  kidx_r, kidx_nxt;
  logic [KEY_AW-1:0]  len_m1_r, len_m1_nxt;
  logic [BYTE_W-1:0]  a_r, a_nxt;
  logic [BYTE_W-1:0]  b_r, b_nxt;
  logic [BYTE_W-1:0]  t_r, t_nxt;
  logic [BYTE_W-1:0]  data_r, data_nxt;
  logic [BYTE_W-1:0]  res_r, res_nxt;
  logic [BYTE_W-1:0]  out_byte_r, out_byte_nxt;

  logic               p_we, p_re;
  logic [PERM_AW-1:0] p_waddr, p_raddr;
  logic [BYTE_W-1:0]  p_wdata, p_rdata;
  logic               k_we, k_re;
  logic [KEY_AW-1:0]  k_raddr;
  logic [BYTE_W-1:0]  k_rdata;

  logic [BYTE_W-1:0]  ks;
  logic [PERM_AW-1:0] j_sched;

  rc4_ram #(.WIDTH(BYTE_W), .DEPTH(PERM_DEPTH)) u_perm (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .re    (p_re),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  rc4_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_KEY_BYTES)) u_key (
    .clk   (clk),
    .we    (k_we),
    .waddr (in_key_index[KEY_AW-1:0]),
    .wdata (in_key_byte),
    .re    (k_re),
    .raddr (k_raddr),
    .rdata (k_rdata)
  );

  assign j_sched = j_r + p_rdata + k_rdata;

  // the swap is written around the keystream read; forward the new words
  always_comb begin
    if (t_r == j_r) begin
      ks = a_r;
    end else if (t_r == i_r) begin
      ks = b_r;
    end else begin
      ks = p_rdata;
    end
  end

  always_comb begin
    i_nxt        = i_r;
    j_nxt        = j_r;
    n_nxt        = n_r;
    kidx_nxt     = kidx_r;
    len_m1_nxt   = len_m1_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    t_nxt        = t_r;
    data_nxt     = data_r;
    res_nxt      = res_r;
    out_byte_nxt = out_byte_r;
    p_we         = 1'b0;
    p_re         = 1'b0;
    p_waddr      = n_r;
    p_wdata      = n_r;
    p_raddr      = n_r;
    k_we         = 1'b0;
    k_re         = 1'b0;
    k_raddr      = kidx_r;

    case (cmd.op)
      OP_KEY_WR: begin
        k_we    = 1'b1;
        res_nxt = '0;
      end
      OP_REJECT: begin
        res_nxt = '0;
      end
      OP_SCHED_START: begin
        res_nxt  = '0;
        n_nxt    = '0;
        j_nxt    = '0;
        kidx_nxt = '0;
        // clamp length to 1..MAX_KEY_BYTES, store as length minus one
        if (in_key_length == '0) begin
          len_m1_nxt = '0;
        end else if (in_key_length > KEY_LEN_W'(MAX_KEY_BYTES)) begin
          len_m1_nxt = KEY_AW'(MAX_KEY_BYTES - 1);
        end else begin
          len_m1_nxt = KEY_AW'(in_key_length - KEY_LEN_W'(1));
        end
      end
      OP_INIT_WR: begin
        p_we  = 1'b1;
        n_nxt = n_r + 1'b1;
      end
      OP_KS_RD_N: begin
        p_re = 1'b1;
        k_re = 1'b1;
      end
      OP_KS_RD_J: begin
        a_nxt   = p_rdata;
        j_nxt   = j_sched;
        p_re    = 1'b1;
        p_raddr = j_sched;
        kidx_nxt = (kidx_r == len_m1_r) ? '0 : kidx_r + 1'b1;
      end
      OP_KS_WR_N: begin
        p_we    = 1'b1;
        p_wdata = p_rdata;
      end
      OP_KS_WR_J: begin
        p_we    = 1'b1;
        p_waddr = j_r;
        p_wdata = a_r;
        n_nxt   = n_r + 1'b1;
        if (n_r == PERM_AW'(PERM_DEPTH - 1)) begin
          i_nxt = '0;
          j_nxt = '0;
        end
      end
      OP_DATA_START: begin
        data_nxt = in_data_byte;
        i_nxt    = i_r + 1'b1;
        p_re     = 1'b1;
        p_raddr  = i_r + 1'b1;
      end
      OP_DATA_RD_J: begin
        a_nxt   = p_rdata;
        j_nxt   = j_r + p_rdata;
        p_re    = 1'b1;
        p_raddr = j_r + p_rdata;
      end
      OP_DATA_WR_I: begin
        b_nxt   = p_rdata;
        t_nxt   = a_r + p_rdata;
        p_we    = 1'b1;
        p_waddr = i_r;
        p_wdata = p_rdata;
        p_re    = 1'b1;
        p_raddr = a_r + p_rdata;
      end
      OP_DATA_WR_J: begin
        p_we    = 1'b1;
        p_waddr = j_r;
        p_wdata = a_r;
        res_nxt = data_r ^ ks;
      end
      default: begin
      end
    endcase

    if (cmd.out_load) begin
      out_byte_nxt = res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= '0;
      j_r <= '0;
    end else begin
      i_r <= i_nxt;
      j_r <= j_nxt;
    end
    n_r        <= n_nxt;
    kidx_r     <= kidx_nxt;
    len_m1_r   <= len_m1_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    t_r        <= t_nxt;
    data_r     <= data_nxt;
    res_r      <= res_nxt;
    out_byte_r <= out_byte_nxt;
  end

  assign stat.n_last = (n_r == PERM_AW'(PERM_DEPTH - 1));
  assign out_byte    = out_byte_r;

endmodule

// File: sv/rc4_ctrl.sv
module rc4_ctrl import rc4_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [1:0]  in_cmd,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  input  rc4_stat_t   stat,
  output rc4_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_KS_A,
    S_KS_B,
    S_KS_C,
    S_KS_D,
    S_DT_B,
    S_DT_C,
    S_DT_D,
    S_DONE
  } state_t;

  state_t      state_r, state_nxt;
  rc4_status_t st_r, st_nxt;
  rc4_status_t out_status_r, out_status_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        sched_r, sched_nxt;

  always_comb begin
    state_nxt      = state_r;
    st_nxt         = st_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    sched_nxt      = sched_r;
    cmd.op         = OP_NONE;
    cmd.out_load   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (rc4_cmd_code_t'(in_cmd))
            CMD_LOAD: begin
              cmd.op    = OP_KEY_WR;
              st_nxt    = ST_KEY_STORED;
              state_nxt = S_DONE;
            end
            CMD_SCHED: begin
              cmd.op    = OP_SCHED_START;
              st_nxt    = ST_SCHED_DONE;
              state_nxt = S_INIT;
            end
            CMD_DATA: begin
              if (sched_r) begin
                cmd.op    = OP_DATA_START;
                st_nxt    = ST_DATA_DONE;
                state_nxt = S_DT_B;
              end else begin
                cmd.op    = OP_REJECT;
                st_nxt    = ST_REJECTED;
                state_nxt = S_DONE;
              end
            end
            default: begin
              cmd.op    = OP_REJECT;
              st_nxt    = ST_REJECTED;
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_INIT: begin
        cmd.op = OP_INIT_WR;
        if (stat.n_last) begin
          state_nxt = S_KS_A;
        end
      end
      S_KS_A: begin
        cmd.op    = OP_KS_RD_N;
        state_nxt = S_KS_B;
      end
      S_KS_B: begin
        cmd.op    = OP_KS_RD_J;
        state_nxt = S_KS_C;
      end
      S_KS_C: begin
        cmd.op    = OP_KS_WR_N;
        state_nxt = S_KS_D;
      end
      S_KS_D: begin
        cmd.op = OP_KS_WR_J;
        if (stat.n_last) begin
          sched_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_KS_A;
        end
      end
      S_DT_B: begin
        cmd.op    = OP_DATA_RD_J;
        state_nxt = S_DT_C;
      end
      S_DT_C: begin
        cmd.op    = OP_DATA_WR_I;
        state_nxt = S_DT_D;
      end
      S_DT_D: begin
        cmd.op    = OP_DATA_WR_J;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      sched_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sched_r     <= sched_nxt;
    end
    st_r         <= st_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

endmodule

// File: sv/rc4_stream_cipher.sv
// A key load or rejected item goes straight to its result; a data byte reads S[i]
// and S[j], writes the swap and XORs in the keystream byte; the key schedule makes
// 256 identity writes, then per swap reads S[n] and the key byte, reads S[j], then
// writes S[n] and S[j], on the permutation RAM's one read and one write port.
// One item at a time: the next is taken the cycle after the output register loads.
// Reset (synchronous, rst_n low): idle, no key scheduled, i and j zero.
module rc4_stream_cipher import rc4_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  rc4_in_if.sink          in_ch,
  rc4_out_if.source       out_ch
);

  rc4_cmd_t  cmd;
  rc4_stat_t stat;

  rc4_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_cmd     (in_ch.cmd),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.status),
    .stat       (stat),
    .cmd        (cmd)
  );

  rc4_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_key_index  (in_ch.key_index),
    .in_key_byte   (in_ch.key_byte),
    .in_key_length (in_ch.key_length),
    .in_data_byte  (in_ch.data_byte),
    .stat          (stat),
    .out_byte      (out_ch.out_byte)
  );

endmodule
